[rtl/bslpc_pkg.sv]
package bslpc_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DataW-1:0] ButtonMaskRst = 8'b0110_1010;
  localparam logic [DataW-1:0] ShortTicksRst = 8'd5;
  localparam logic [DataW-1:0] LongUnitsRst = 8'd20;
  localparam logic [DataW-1:0] IdlePattern = 8'b1111_1111;
  localparam logic [DataW-1:0] LongMarkClear = 8'b1111_1101;
  localparam logic [DataW-1:0] LimitFloor = 8'd2;

  localparam logic [CfgIdxW-1:0] CfgButtonMask = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgShortTicks = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLongUnits = 2'd2;

  typedef struct packed {
    logic [DataW-1:0] button_mask;
    logic [DataW-1:0] short_ticks;
    logic [DataW-1:0] long_units;
  } cfg_t;

endpackage

[rtl/bslpc_cfg_regs.sv]
module bslpc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bslpc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bslpc_pkg::DataW-1:0]     cfg_wdata_i,
  output bslpc_pkg::cfg_t                 cfg_o
);
  import bslpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgButtonMask: cfg_d.button_mask = cfg_wdata_i;
        CfgShortTicks: cfg_d.short_ticks = cfg_wdata_i;
        CfgLongUnits:  cfg_d.long_units  = cfg_wdata_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.button_mask <= ButtonMaskRst;
      cfg_q.short_ticks <= ShortTicksRst;
      cfg_q.long_units  <= LongUnitsRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/bslpc_classify.sv]
module bslpc_classify (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [bslpc_pkg::DataW-1:0] pin_sample_i,
  input  logic                        speed_request_i,
  input  bslpc_pkg::cfg_t             cfg_i,
  output logic                        press_event_o,
  output logic [bslpc_pkg::DataW-1:0] press_code_o
);
  import bslpc_pkg::*;

  logic [DataW-1:0] prev_q, prev_d;
  logic [DataW-1:0] tick_q, tick_d;
  logic [DataW-1:0] unit_q, unit_d;
  logic [DataW-1:0] limit_q, limit_d;
  logic [DataW-1:0] key_q, key_d;
  logic             long_seen_q, long_seen_d;
  logic             accel_q, accel_d;

  logic [DataW-1:0] pattern;
  logic [DataW-1:0] tick_inc;
  logic [DataW-1:0] unit_inc;
  logic [DataW-1:0] limit_half;
  logic             short_ok;
  logic             long_ok;
  logic             event_d;

  always_comb begin
    pattern     = pin_sample_i | cfg_i.button_mask;
    tick_inc    = tick_q + 8'd1;
    unit_inc    = unit_q + 8'd1;
    limit_half  = limit_q >> 1;
    short_ok    = ((tick_q >= cfg_i.short_ticks) || (unit_q != '0)) && !long_seen_q;
    long_ok     = unit_q >= limit_q;
    prev_d      = pattern;
    tick_d      = tick_q;
    unit_d      = unit_q;
    limit_d     = limit_q;
    key_d       = key_q;
    long_seen_d = long_seen_q;
    accel_d     = accel_q;
    event_d     = 1'b0;
    if ((pattern == IdlePattern) || (pattern != prev_q)) begin
      if (short_ok) begin
        event_d = 1'b1;
        key_d   = prev_q;
      end
      if (long_ok) begin
        event_d = 1'b1;
        key_d   = prev_q & LongMarkClear;
      end
      accel_d     = 1'b0;
      long_seen_d = 1'b0;
      limit_d     = cfg_i.long_units;
      tick_d      = '0;
      unit_d      = '0;
    end else begin
      accel_d = accel_q | speed_request_i;
      if (tick_inc >= cfg_i.short_ticks) begin
        tick_d = '0;
        if (unit_inc >= limit_q) begin
          key_d       = prev_q & LongMarkClear;
          unit_d      = '0;
          event_d     = 1'b1;
          long_seen_d = 1'b1;
          if (accel_d) begin
            limit_d = (limit_half <= LimitFloor) ? LimitFloor : limit_half;
          end
        end else begin
          unit_d = unit_inc;
        end
      end else begin
        tick_d = tick_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      tick_q      <= '0;
      unit_q      <= '0;
      limit_q     <= LongUnitsRst;
      key_q       <= '0;
      long_seen_q <= 1'b0;
      accel_q     <= 1'b0;
    end else if (step_i) begin
      prev_q      <= prev_d;
      tick_q      <= tick_d;
      unit_q      <= unit_d;
      limit_q     <= limit_d;
      key_q       <= key_d;
      long_seen_q <= long_seen_d;
      accel_q     <= accel_d;
    end
  end

  assign press_event_o = event_d;
  assign press_code_o  = key_d;

endmodule

[rtl/button_short_long_press_classifier_core.sv]
// A word goes from the input register through the classifier into the result register.
// Throughput: one word per cycle unless a stalled result blocks the input register.
// The input register advances into the classifier whenever the result register is free.
// Reset: asynchronous, active low; clears both valid flags and the hold state,
// and loads the configuration registers and the long limit with their defaults.
module button_short_long_press_classifier_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bslpc_pkg::DataW-1:0]   pin_sample_i,
  input  logic                          speed_request_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          press_event_o,
  output logic [bslpc_pkg::DataW-1:0]   press_code_o,
  input  logic                          cfg_we_i,
  input  logic [bslpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bslpc_pkg::DataW-1:0]   cfg_wdata_i
);
  import bslpc_pkg::*;

  cfg_t             cfg;
  logic             in_valid_q;
  logic [DataW-1:0] pin_q;
  logic             req_q;
  logic             out_valid_q;
  logic             event_q;
  logic [DataW-1:0] code_q;
  logic             in_fire;
  logic             advance;
  logic             cls_event;
  logic [DataW-1:0] cls_code;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  bslpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bslpc_classify u_classify (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .pin_sample_i    (pin_q),
    .speed_request_i (req_q),
    .cfg_i           (cfg),
    .press_event_o   (cls_event),
    .press_code_o    (cls_code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pin_q <= pin_sample_i;
      req_q <= speed_request_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      event_q <= cls_event;
      code_q  <= cls_code;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign press_event_o = event_q;
  assign press_code_o  = code_q;

  a_advance_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not filled after advance");

  a_input_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(pin_q) && $stable(req_q)))
    else $error("input register lost a word while blocked");

  a_no_advance_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !advance)
    else $error("advance while result word is stalled");

endmodule
